// File: rtl/core/tmbf_pkg.sv
// shared types, constants and helpers for the tempo map beat/frame converter
// no dependencies; imported by every module of the block but tmbf_ram
package tmbf_pkg;

	localparam int MAX_CHANGES_DEF = 16;

	localparam int MODE_W   = 2;
	localparam int BEAT_W   = 32;
	localparam int TEMPO_W  = 16;
	localparam int FRAME_W  = 48;
	localparam int RATE_W   = 20;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;
	localparam int ACC_W    = 64;
	localparam int PROD_W   = BEAT_W + RATE_W;
	localparam int ENTRY_W  = BEAT_W + TEMPO_W;
	localparam int DEN_W    = 32;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_B2F    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_F2B    = 2'd3;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

	// register index, taken from paddr bit 2
	localparam logic REG_DEFAULT_TEMPO = 1'b0;
	localparam logic REG_SAMPLE_RATE   = 1'b1;

	localparam logic [TEMPO_W-1:0] DEFAULT_TEMPO_RST = 16'd7680;
	localparam logic [RATE_W-1:0]  SAMPLE_RATE_RST   = 20'd48000;

	localparam logic [ACC_W-1:0]   FRAME_SAT_LIM = 64'hFFFF_FFFF_FFFF_8000;
	localparam logic [ACC_W-1:0]   ROUND_HALF    = 64'h0000_0000_0000_8000;
	localparam logic [FRAME_W-1:0] FRAME_MAX     = 48'hFFFF_FFFF_FFFF;
	localparam logic [BEAT_W-1:0]  BEAT_MAX      = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [TEMPO_W-1:0] default_tempo;
		logic [RATE_W-1:0]  sample_rate;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_INS_RD,
		ST_INS_CMP,
		ST_WALK_RD,
		ST_WALK_EVAL,
		ST_SEG_MUL,
		ST_SEG_DIV,
		ST_DIV_WAIT,
		ST_SEG_ACC,
		ST_INV_MUL_LO,
		ST_INV_MUL_HI,
		ST_INV_SUM,
		ST_INV_CHK,
		ST_INV_FIN,
		ST_B2F_FIN
	} state_t;

	// x * 3840 as x*4096 - x*256
	function automatic logic [ACC_W-1:0] sec_scale(input logic [PROD_W-1:0] x);
		logic [ACC_W-1:0] xe;
		xe = ACC_W'(x);
		return (xe << 12) - (xe << 8);
	endfunction

endpackage

// File: rtl/core/tempo_map_beat_frame_converter.sv
// top level of the tempo map beat/frame converter: sequencer, shared multiplier
// depends on tmbf_pkg, tmbf_cfg, tmbf_div, tmbf_ram
//
// usage
//  - configuration: apb port, default_tempo at byte 0, sample_rate at byte 4;
//    write only while busy is low and no result is pending
//  - command channel: an item is taken at a clock edge with start high and busy low;
//    busy then stays high until the result beat is issued
//  - result channel: done is high for exactly one cycle with frame_result,
//    beat_result, status and entry_count; the receiver cannot stall it
//  - operation: clear empties the table; an insert shifts each larger entry up one
//    place; a conversion walks the tempo segments (table read, multiply, 64-step
//    shared divider, accumulate), and a frame to beat conversion ends with an
//    inversion through the same divider
//  - the 64-step divider is shared by every segment and the inversion, and
//    sets the throughput: one item at a time
//  - reset clears the table count, sets the registers to 7680 (120 bpm) and
//    48000, and leaves the table storage unwritten
module tempo_map_beat_frame_converter import tmbf_pkg::*; #(
	parameter int MAX_CHANGES = MAX_CHANGES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// apb configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	// command
	input  logic                start,
	output logic                busy,
	input  logic [MODE_W-1:0]   mode,
	input  logic [BEAT_W-1:0]   beat_position,
	input  logic [TEMPO_W-1:0]  entry_tempo,
	input  logic [FRAME_W-1:0]  frame_position,
	// result
	output logic                done,
	output logic [FRAME_W-1:0]  frame_result,
	output logic [BEAT_W-1:0]   beat_result,
	output logic [STATUS_W-1:0] status,
	output logic [COUNT_W-1:0]  entry_count
);

	localparam int CW = $clog2(MAX_CHANGES + 1);
	localparam int AW = (MAX_CHANGES > 1) ? $clog2(MAX_CHANGES) : 1;

	cfg_t cfg;

	// sequencer state and control
	state_t        state_q, state_nx;
	logic [CW-1:0] count_q, count_nx;
	logic          done_q;

	// item and walk registers
	logic [MODE_W-1:0]  mode_q;
	logic [BEAT_W-1:0]  beat_q;
	logic [TEMPO_W-1:0] tempo_q;
	logic [CW-1:0]      pos_q;
	logic [CW-1:0]      idx_q;
	logic [BEAT_W-1:0]  last_q;
	logic [TEMPO_W-1:0] cur_tempo_q;
	logic [BEAT_W-1:0]  cb_q;
	logic [TEMPO_W-1:0] ct_q;
	logic [BEAT_W-1:0]  db_q;
	logic               final_q;
	logic               inv_q;
	logic               sat_q;
	logic [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]   rem_q;
	logic [PROD_W-1:0]  prod_q;
	logic [47:0]        p0_q;
	logic [16:0]        num_hi_q;
	logic [ACC_W-1:0]   num_lo_q;

	// result registers
	logic [FRAME_W-1:0]  frame_q;
	logic [BEAT_W-1:0]   beatr_q;
	logic [STATUS_W-1:0] status_q;
	logic [COUNT_W-1:0]  ecount_q;

	// combinational
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [AW-1:0]      ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [BEAT_W-1:0]  rd_beat;
	logic [TEMPO_W-1:0] rd_tempo;
	logic [CW-1:0]      pos_dec;
	logic [TEMPO_W-1:0] eff_tempo;
	logic [RATE_W-1:0]  eff_rate;
	logic [DEN_W-1:0]   rate_den;
	logic [BEAT_W-1:0]  mul_a;
	logic [RATE_W-1:0]  mul_b;
	logic [PROD_W-1:0]  mul_p;
	logic               div_start;
	logic               div_done;
	logic [DEN_W-1:0]   div_hi;
	logic [ACC_W-1:0]   div_lo;
	logic [DEN_W-1:0]   div_den;
	logic [ACC_W-1:0]   div_quo;
	logic [ACC_W:0]     acc_sum;
	logic [ACC_W-1:0]   acc_rnd;
	logic [80:0]        num_sum;
	logic               fin;
	logic [FRAME_W-1:0]  fin_frame;
	logic [BEAT_W-1:0]   fin_beat;
	logic [STATUS_W-1:0] fin_status;

	tmbf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// tempo table, one entry = {beat, tempo}
	tmbf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_CHANGES),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tmbf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_hi (div_hi),
		.num_lo (div_lo),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign rd_beat  = ram_rdata[ENTRY_W-1:TEMPO_W];
	assign rd_tempo = ram_rdata[TEMPO_W-1:0];
	assign pos_dec  = pos_q - CW'(1);

	// zero tempo and zero rate count as one lsb
	assign eff_tempo = (cur_tempo_q == '0) ? TEMPO_W'(1) : cur_tempo_q;
	assign eff_rate  = (cfg.sample_rate == '0) ? RATE_W'(1) : cfg.sample_rate;
	assign rate_den  = DEN_W'(sec_scale(PROD_W'(eff_rate)));

	// the one shared multiplier, 32 x 20
	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// divider operands: segment length, or the frame to beat inversion
	assign div_hi  = inv_q ? DEN_W'(num_hi_q) : '0;
	assign div_lo  = inv_q ? num_lo_q : sec_scale(prod_q);
	assign div_den = inv_q ? rate_den : DEN_W'(eff_tempo);

	assign acc_sum = {1'b0, acc_q} + {1'b0, div_quo};
	assign acc_rnd = acc_q + ROUND_HALF;
	// rem*t split in two 32x16 halves, plus half the divisor for rounding
	assign num_sum = 81'(p0_q) + {1'b0, prod_q[47:0], 32'b0} + 81'(rate_den >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			count_q <= count_nx;
			done_q  <= fin;
		end
	end

	always_comb begin
		state_nx   = state_q;
		count_nx   = count_q;
		ram_we     = 1'b0;
		ram_waddr  = pos_q[AW-1:0];
		ram_wdata  = {beat_q, tempo_q};
		ram_raddr  = idx_q[AW-1:0];
		div_start  = 1'b0;
		mul_a      = db_q;
		mul_b      = eff_rate;
		fin        = 1'b0;
		fin_frame  = '0;
		fin_beat   = '0;
		fin_status = STATUS_OK;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nx = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (mode_q)
					MODE_CLEAR: begin
						count_nx = '0;
						fin      = 1'b1;
						state_nx = ST_IDLE;
					end
					MODE_INSERT: begin
						if (count_q >= CW'(MAX_CHANGES)) begin
							fin_status = STATUS_FULL;
							fin        = 1'b1;
							state_nx   = ST_IDLE;
						end else begin
							state_nx = ST_INS_RD;
						end
					end
					default: begin
						state_nx = ST_WALK_RD;
					end
				endcase
			end
			ST_INS_RD: begin
				if (pos_q == '0) begin
					ram_we   = 1'b1;
					count_nx = count_q + CW'(1);
					fin      = 1'b1;
					state_nx = ST_IDLE;
				end else begin
					ram_raddr = pos_dec[AW-1:0];
					state_nx  = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				ram_we = 1'b1;
				if (rd_beat > beat_q) begin
					// shift the larger entry up one place
					ram_wdata = ram_rdata;
					state_nx  = ST_INS_RD;
				end else begin
					count_nx = count_q + CW'(1);
					fin      = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			ST_WALK_RD: begin
				if (idx_q < count_q) begin
					state_nx = ST_WALK_EVAL;
				end else if (mode_q == MODE_B2F) begin
					state_nx = ST_SEG_MUL;
				end else begin
					state_nx = ST_INV_MUL_LO;
				end
			end
			ST_WALK_EVAL: begin
				state_nx = ST_SEG_MUL;
			end
			ST_SEG_MUL: begin
				state_nx = ST_SEG_DIV;
			end
			ST_SEG_DIV: begin
				div_start = 1'b1;
				state_nx  = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_nx = inv_q ? ST_INV_FIN : ST_SEG_ACC;
				end
			end
			ST_SEG_ACC: begin
				if (mode_q == MODE_B2F) begin
					state_nx = final_q ? ST_B2F_FIN : ST_WALK_RD;
				end else begin
					state_nx = (rem_q <= div_quo) ? ST_INV_MUL_LO : ST_WALK_RD;
				end
			end
			ST_INV_MUL_LO: begin
				mul_a    = rem_q[31:0];
				mul_b    = RATE_W'(eff_tempo);
				state_nx = ST_INV_MUL_HI;
			end
			ST_INV_MUL_HI: begin
				mul_a    = rem_q[63:32];
				mul_b    = RATE_W'(eff_tempo);
				state_nx = ST_INV_SUM;
			end
			ST_INV_SUM: begin
				state_nx = ST_INV_CHK;
			end
			ST_INV_CHK: begin
				if (DEN_W'(num_hi_q) >= rate_den) begin
					fin_beat   = BEAT_MAX;
					fin_status = STATUS_SAT;
					fin        = 1'b1;
					state_nx   = ST_IDLE;
				end else begin
					div_start = 1'b1;
					state_nx  = ST_DIV_WAIT;
				end
			end
			ST_INV_FIN: begin
				fin      = 1'b1;
				state_nx = ST_IDLE;
				if ((div_quo[63:32] != '0) || (div_quo[31:0] > (BEAT_MAX - last_q))) begin
					fin_beat   = BEAT_MAX;
					fin_status = STATUS_SAT;
				end else begin
					fin_beat = last_q + div_quo[31:0];
				end
			end
			ST_B2F_FIN: begin
				fin      = 1'b1;
				state_nx = ST_IDLE;
				if (sat_q || (acc_q >= FRAME_SAT_LIM)) begin
					fin_frame  = FRAME_MAX;
					fin_status = STATUS_SAT;
				end else begin
					fin_frame = acc_rnd[ACC_W-1:16];
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			frame_q  <= fin_frame;
			beatr_q  <= fin_beat;
			status_q <= fin_status;
			ecount_q <= COUNT_W'(count_nx);
		end
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					mode_q  <= mode;
					beat_q  <= beat_position;
					tempo_q <= entry_tempo;
					rem_q   <= {frame_position, 16'b0};
				end
			end
			ST_DISPATCH: begin
				pos_q       <= count_q;
				idx_q       <= '0;
				last_q      <= '0;
				cur_tempo_q <= cfg.default_tempo;
				acc_q       <= '0;
				sat_q       <= 1'b0;
				inv_q       <= 1'b0;
			end
			ST_INS_CMP: begin
				if (rd_beat > beat_q) begin
					pos_q <= pos_dec;
				end
			end
			ST_WALK_RD: begin
				// past the last change: the tail segment up to the query beat
				if (idx_q >= count_q) begin
					db_q    <= beat_q - last_q;
					final_q <= 1'b1;
				end
			end
			ST_WALK_EVAL: begin
				cb_q <= rd_beat;
				ct_q <= rd_tempo;
				if ((mode_q == MODE_B2F) && (rd_beat >= beat_q)) begin
					db_q    <= beat_q - last_q;
					final_q <= 1'b1;
				end else begin
					db_q    <= rd_beat - last_q;
					final_q <= 1'b0;
				end
			end
			ST_SEG_MUL, ST_INV_MUL_LO: begin
				prod_q <= mul_p;
			end
			ST_INV_MUL_HI: begin
				p0_q   <= prod_q[47:0];
				prod_q <= mul_p;
			end
			ST_SEG_ACC: begin
				if (mode_q == MODE_B2F) begin
					acc_q <= acc_sum[ACC_W-1:0];
					sat_q <= sat_q | acc_sum[ACC_W];
					if (!final_q) begin
						last_q      <= cb_q;
						cur_tempo_q <= ct_q;
						idx_q       <= idx_q + CW'(1);
					end
				end else if (rem_q > div_quo) begin
					rem_q       <= rem_q - div_quo;
					last_q      <= cb_q;
					cur_tempo_q <= ct_q;
					idx_q       <= idx_q + CW'(1);
				end
			end
			ST_INV_SUM: begin
				num_hi_q <= num_sum[80:64];
				num_lo_q <= num_sum[63:0];
				// divider operands switch to the inversion before its start
				inv_q    <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign frame_result = frame_q;
	assign beat_result  = beatr_q;
	assign status       = status_q;
	assign entry_count  = ecount_q;

endmodule

// File: rtl/core/tmbf_ram.sv
// generic single-write ram with registered read
// no dependencies
module tmbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/tmbf_div.sv
// shared restoring divider, one quotient bit per cycle, 64 steps
// depends on tmbf_pkg
module tmbf_div import tmbf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DEN_W-1:0] num_hi,
	input  logic [ACC_W-1:0] num_lo,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [ACC_W-1:0] quo
);

	logic             run_q;
	logic             done_q;
	logic [5:0]       cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [ACC_W-1:0] lo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_sh;
	logic             take;

	// num_hi must be below den, so the remainder stays within 32 bits
	assign rem_sh = {rem_q, lo_q[ACC_W-1]};
	assign take   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num_hi;
			lo_q  <= num_lo;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= take ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
			lo_q  <= {lo_q[ACC_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quo  = lo_q;

endmodule

// File: rtl/core/tmbf_cfg.sv
// apb register file: default tempo and sample rate
// depends on tmbf_pkg
module tmbf_cfg import tmbf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [TEMPO_W-1:0] tempo_q;
	logic [RATE_W-1:0]  rate_q;
	logic               wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_q <= DEFAULT_TEMPO_RST;
			rate_q  <= SAMPLE_RATE_RST;
		end else if (wr) begin
			case (paddr[2])
				REG_DEFAULT_TEMPO: begin
					tempo_q <= pwdata[TEMPO_W-1:0];
				end
				REG_SAMPLE_RATE: begin
					rate_q <= pwdata[RATE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SAMPLE_RATE: prdata = DATA_W'(rate_q);
			default:         prdata = DATA_W'(tempo_q);
		endcase
	end

	assign cfg.default_tempo = tempo_q;
	assign cfg.sample_rate   = rate_q;

endmodule

// File: rtl/core/tmbf_checker.sv
// port-level checks for the tempo map beat/frame converter, bound to the top level
// depends on tmbf_pkg and tempo_map_beat_frame_converter
module tmbf_checker import tmbf_pkg::*; #(
	parameter int MAX_CHANGES = MAX_CHANGES_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic [FRAME_W-1:0]  frame_result,
	input logic [BEAT_W-1:0]   beat_result,
	input logic [STATUS_W-1:0] status,
	input logic [COUNT_W-1:0]  entry_count
);

	// a taken command always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted command did not raise busy");

	// a result beat only closes a command that was in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result beat without a command in progress");

	// a dropped insert reports a full table
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STATUS_FULL) |-> entry_count == COUNT_W'(MAX_CHANGES))
		else $error("full status with a table that is not full");

	// only one of the two conversion results is ever nonzero
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (frame_result == '0) || (beat_result == '0))
		else $error("frame and beat results both nonzero");

endmodule

bind tempo_map_beat_frame_converter tmbf_checker #(
	.MAX_CHANGES (MAX_CHANGES)
) u_tmbf_checker (.*);
